// ----- rtl/core/ipe_pkg.sv -----
package ipe_pkg;

  localparam int PART_W        = 6;
  localparam int REST_W        = 7;
  localparam int BEAT_W        = 8;
  localparam int MAX_TOTAL_DEF = 32;

  localparam logic OP_START = 1'b0;
  localparam logic OP_NEXT  = 1'b1;

  typedef struct packed {
    logic [REST_W-1:0] a;
    logic [REST_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [REST_W-1:0] diff;
    logic              gt;
  } alu_rsp_t;

endpackage

// ----- rtl/core/integer_partition_enumerator.sv -----
// start: parts go out in order through emit read, emit wait and hold, each held until taken
// next: walk past trailing ones, lower the last larger part, rewrite the parts after it, then as start
// one item at a time; ready only between items, set by the sequencer and its one-read one-write ram
// exhausted: in the cycle after a refused beat; past the final partition, once the walk reaches part zero
// synchronous active-high reset: nothing started, top index zero, no output pending
// part store is not cleared by reset; entries are always written before they are read
module integer_partition_enumerator #(
  parameter int MAX_TOTAL = ipe_pkg::MAX_TOTAL_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [ipe_pkg::BEAT_W-1:0] s_axis_tdata,   // total
  input  logic [0:0]                 s_axis_tuser,   // operation
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [ipe_pkg::BEAT_W-1:0] m_axis_tdata,   // part_value
  output logic                       m_axis_tlast,
  output logic [1:0]                 m_axis_tuser    // final_partition, exhausted
);

  localparam int IDX_W = $clog2(MAX_TOTAL);

  logic                       mem_we;
  logic [IDX_W-1:0]           mem_waddr;
  logic [ipe_pkg::PART_W-1:0] mem_wdata;
  logic [IDX_W-1:0]           mem_raddr;
  logic [ipe_pkg::PART_W-1:0] mem_rdata;
  ipe_pkg::alu_req_t          alu_req;
  ipe_pkg::alu_rsp_t          alu_rsp;
  logic [ipe_pkg::PART_W-1:0] out_part;
  logic                       out_fin;
  logic                       out_exh;

  ipe_seq #(
    .MAX_TOTAL(MAX_TOTAL),
    .IDX_W    (IDX_W)
  ) u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_op    (s_axis_tuser[0]),
    .in_total (s_axis_tdata[ipe_pkg::PART_W-1:0]),
    .out_valid(m_axis_tvalid),
    .out_ready(m_axis_tready),
    .out_part (out_part),
    .out_last (m_axis_tlast),
    .out_fin  (out_fin),
    .out_exh  (out_exh),
    .mem_we   (mem_we),
    .mem_waddr(mem_waddr),
    .mem_wdata(mem_wdata),
    .mem_raddr(mem_raddr),
    .mem_rdata(mem_rdata),
    .alu_req  (alu_req),
    .alu_rsp  (alu_rsp)
  );

  ipe_alu u_alu (
    .req(alu_req),
    .rsp(alu_rsp)
  );

  ipe_ram #(
    .WIDTH(ipe_pkg::PART_W),
    .DEPTH(MAX_TOTAL),
    .AW   (IDX_W)
  ) u_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  assign m_axis_tdata = ipe_pkg::BEAT_W'(out_part);
  assign m_axis_tuser = {out_exh, out_fin};

endmodule

// ----- rtl/core/ipe_ram.sv -----
module ipe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/ipe_alu.sv -----
module ipe_alu (
  input  ipe_pkg::alu_req_t req,
  output ipe_pkg::alu_rsp_t rsp
);

  always_comb begin
    rsp.diff = req.a - req.b;
    rsp.gt   = (req.a > req.b);
  end

endmodule

// ----- rtl/core/ipe_seq.sv -----
module ipe_seq #(
  parameter int MAX_TOTAL = ipe_pkg::MAX_TOTAL_DEF,
  parameter int IDX_W     = $clog2(MAX_TOTAL)
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_op,
  input  logic [ipe_pkg::PART_W-1:0] in_total,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [ipe_pkg::PART_W-1:0] out_part,
  output logic                       out_last,
  output logic                       out_fin,
  output logic                       out_exh,
  output logic                       mem_we,
  output logic [IDX_W-1:0]           mem_waddr,
  output logic [ipe_pkg::PART_W-1:0] mem_wdata,
  output logic [IDX_W-1:0]           mem_raddr,
  input  logic [ipe_pkg::PART_W-1:0] mem_rdata,
  output ipe_pkg::alu_req_t          alu_req,
  input  ipe_pkg::alu_rsp_t          alu_rsp
);

  typedef enum logic [2:0] {
    S_IDLE, S_WALK_RD, S_WALK_CHK, S_DEC, S_SPREAD, S_EMIT_RD, S_EMIT_WAIT, S_HOLD
  } state_t;

  state_t                       state;
  logic                         running;
  logic [IDX_W-1:0]             top;
  logic [IDX_W-1:0]             k;
  logic [IDX_W-1:0]             idx;
  logic [ipe_pkg::REST_W-1:0]   rest;
  logic [ipe_pkg::PART_W-1:0]   cur;
  logic                         fin;
  logic                         out_done;

  logic                         total_ok;
  logic                         k_at_max;
  logic                         go_exh;

  assign in_ready = (state == S_IDLE);
  assign total_ok = (in_total != '0) &&
                    ({1'b0, in_total} <= ipe_pkg::REST_W'(MAX_TOTAL));
  assign k_at_max = (k == IDX_W'(MAX_TOTAL - 1));

  always_comb begin
    mem_we      = 1'b0;
    mem_waddr   = k;
    mem_wdata   = cur;
    mem_raddr   = k;
    alu_req.a   = rest;
    alu_req.b   = {1'b0, cur};
    go_exh      = 1'b0;
    case (state)
      S_IDLE: begin
        mem_waddr = '0;
        mem_wdata = in_total;
        mem_we    = in_valid && (in_op == ipe_pkg::OP_START) && total_ok;
        if (in_valid) begin
          go_exh = (in_op == ipe_pkg::OP_START) ? !total_ok : !running;
        end
      end
      S_WALK_CHK: begin
        go_exh = ((mem_rdata == ipe_pkg::PART_W'(1)) && (k == '0)) || (mem_rdata == '0);
      end
      S_DEC: begin
        alu_req.a = {1'b0, cur};
        alu_req.b = ipe_pkg::REST_W'(1);
        mem_we    = 1'b1;
        mem_wdata = alu_rsp.diff[ipe_pkg::PART_W-1:0];
      end
      S_SPREAD: begin
        mem_waddr = k + IDX_W'(1);
        if (alu_rsp.gt) begin
          go_exh    = k_at_max || (cur == '0);
          mem_we    = !go_exh;
          mem_wdata = cur;
        end else begin
          go_exh    = k_at_max;
          mem_we    = !go_exh;
          mem_wdata = rest[ipe_pkg::PART_W-1:0];
        end
      end
      S_EMIT_RD: begin
        mem_raddr = idx;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      running   <= 1'b0;
      top       <= '0;
      out_valid <= 1'b0;
    end else if (go_exh) begin
      running   <= 1'b0;
      out_valid <= 1'b1;
      out_part  <= '0;
      out_last  <= 1'b0;
      out_fin   <= 1'b0;
      out_exh   <= 1'b1;
      out_done  <= 1'b1;
      state     <= S_HOLD;
    end else begin
      case (state)
        S_IDLE: begin
          rest <= '0;
          k    <= top;
          idx  <= '0;
          if (in_valid) begin
            if (in_op == ipe_pkg::OP_START) begin
              running <= 1'b1;
              top     <= '0;
              state   <= S_EMIT_RD;
            end else begin
              state <= S_WALK_RD;
            end
          end
        end
        S_WALK_RD: begin
          state <= S_WALK_CHK;
        end
        S_WALK_CHK: begin
          if (mem_rdata == ipe_pkg::PART_W'(1)) begin
            rest  <= rest + ipe_pkg::REST_W'(1);
            k     <= k - IDX_W'(1);
            state <= S_WALK_RD;
          end else begin
            cur   <= mem_rdata;
            state <= S_DEC;
          end
        end
        S_DEC: begin
          cur   <= alu_rsp.diff[ipe_pkg::PART_W-1:0];
          rest  <= rest + ipe_pkg::REST_W'(1);
          state <= S_SPREAD;
        end
        S_SPREAD: begin
          if (alu_rsp.gt) begin
            rest <= alu_rsp.diff;
            k    <= k + IDX_W'(1);
          end else begin
            top   <= k + IDX_W'(1);
            idx   <= '0;
            state <= S_EMIT_RD;
          end
        end
        S_EMIT_RD: begin
          state <= S_EMIT_WAIT;
        end
        S_EMIT_WAIT: begin
          out_valid <= 1'b1;
          out_part  <= mem_rdata;
          out_last  <= (idx == top);
          out_done  <= (idx == top);
          out_exh   <= 1'b0;
          if (idx == '0) begin
            fin     <= (mem_rdata == ipe_pkg::PART_W'(1));
            out_fin <= (mem_rdata == ipe_pkg::PART_W'(1));
          end else begin
            out_fin <= fin;
          end
          state <= S_HOLD;
        end
        S_HOLD: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            if (out_done) begin
              state <= S_IDLE;
            end else begin
              idx   <= idx + IDX_W'(1);
              state <= S_EMIT_RD;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- rtl/core/ipe_checker.sv -----
module ipe_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tlast,
  input logic [1:0] m_axis_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output beat dropped or changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input ready while a result is pending");

  a_exh_shape: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[1] |->
      m_axis_tdata == 8'd0 && !m_axis_tlast && !m_axis_tuser[0])
    else $error("exhausted beat carries data or marks");

  a_ready_after_run: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tready && (m_axis_tlast || m_axis_tuser[1]) |=> s_axis_tready)
    else $error("not ready after the last beat of a run");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid && s_axis_tready)
    else $error("output pending or not ready after reset");

endmodule

bind integer_partition_enumerator ipe_checker u_chk (.*);

// ----- tb/integer_partition_enumerator_test.sv -----
module integer_partition_enumerator_test;

  localparam int MAX_TOTAL = ipe_pkg::MAX_TOTAL_DEF;
  localparam int RANDOM_ITEMS = 75;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 150;

  typedef struct {
    logic                       op;
    logic [ipe_pkg::PART_W-1:0] total;
  } enum_req_t;

  typedef struct packed {
    logic [ipe_pkg::PART_W-1:0] value;
    logic                       last;
    logic                       fin;
    logic                       exh;
  } part_beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [ipe_pkg::BEAT_W-1:0] s_axis_tdata = '0;      // total
  logic [0:0] s_axis_tuser = ipe_pkg::OP_START;       // operation
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [ipe_pkg::BEAT_W-1:0] m_axis_tdata;           // part_value
  logic m_axis_tlast;
  logic [1:0] m_axis_tuser;                           // final_partition, exhausted

  integer_partition_enumerator #(
    .MAX_TOTAL(MAX_TOTAL)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tlast(m_axis_tlast),
    .m_axis_tuser(m_axis_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  enum_req_t pending_items[$];
  part_beat_t parts_due[$];

  logic [ipe_pkg::PART_W-1:0] parts [MAX_TOTAL];
  int top_ix = 0;
  bit seq_live = 1'b0;

  int cycles = 0;
  int errors = 0;
  int items_taken = 0;
  int beats_checked = 0;
  int partitions_seen = 0;
  int exhausted_seen = 0;
  int finals_seen = 0;
  int widest = 0;

  bit in_fire = 1'b0;
  bit out_fire = 1'b0;
  int gap_left = 0;
  int stall_left = 0;
  bit send_burst = 1'b0;
  bit recv_burst = 1'b0;

  function automatic bit step_partition();
    int k;
    int rest;
    k = top_ix;
    rest = 0;
    while (parts[k] == 1) begin
      rest++;
      if (k == 0) return 1'b0;
      k--;
    end
    if (parts[k] == 0) return 1'b0;
    parts[k] = parts[k] - 1'b1;
    rest++;
    while (rest > parts[k]) begin
      if (k + 1 >= MAX_TOTAL || parts[k] == 0) return 1'b0;
      parts[k+1] = parts[k];
      rest -= parts[k];
      k++;
    end
    if (k + 1 >= MAX_TOTAL) return 1'b0;
    parts[k+1] = ipe_pkg::PART_W'(rest);
    top_ix = k + 1;
    return 1'b1;
  endfunction

  task automatic push_exhausted();
    part_beat_t b;
    b = '{value: '0, last: 1'b0, fin: 1'b0, exh: 1'b1};
    parts_due = {parts_due, b};
  endtask

  task automatic push_partition();
    part_beat_t b;
    logic all_ones;
    all_ones = (parts[0] == 1);
    for (int i = 0; i <= top_ix; i++) begin
      b = '{value: parts[i], last: (i == top_ix), fin: all_ones, exh: 1'b0};
      parts_due = {parts_due, b};
    end
    partitions_seen++;
    if (top_ix + 1 > widest) widest = top_ix + 1;
  endtask

  task automatic predict_partition(input logic op,
                                   input logic [ipe_pkg::PART_W-1:0] total);
    if (op == ipe_pkg::OP_START) begin
      if (total == 0 || total > MAX_TOTAL) begin
        seq_live = 1'b0;
        push_exhausted();
      end else begin
        parts[0] = total;
        top_ix = 0;
        seq_live = 1'b1;
        push_partition();
      end
    end else if (!seq_live) begin
      push_exhausted();
    end else if (!step_partition()) begin
      seq_live = 1'b0;
      push_exhausted();
    end else begin
      push_partition();
    end
  endtask

  task automatic report_mismatch(input string what, input part_beat_t want,
                                 input part_beat_t got);
    errors++;
    if (errors <= 10) begin
      $display("cycle %0d %s: want part %0d last %b fin %b exh %b, got %0d %b %b %b",
               cycles, what, want.value, want.last, want.fin, want.exh,
               got.value, got.last, got.fin, got.exh);
    end
  endtask

  task automatic queue_item(input logic op, input logic [ipe_pkg::PART_W-1:0] total);
    enum_req_t r;
    r.op = op;
    r.total = total;
    pending_items = {pending_items, r};
  endtask

  // monitor: predict on accepted input beats, check output beats
  always @(posedge clk) begin
    part_beat_t got;
    part_beat_t want;
    cycles <= cycles + 1;
    in_fire <= !rst && s_axis_tvalid && s_axis_tready;
    out_fire <= !rst && m_axis_tvalid && m_axis_tready;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        items_taken++;
        predict_partition(s_axis_tuser[0], s_axis_tdata[ipe_pkg::PART_W-1:0]);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = '{value: m_axis_tdata[ipe_pkg::PART_W-1:0], last: m_axis_tlast,
                fin: m_axis_tuser[0], exh: m_axis_tuser[1]};
        beats_checked++;
        if (got.exh) exhausted_seen++;
        if (got.fin && got.last) finals_seen++;
        if (parts_due.size() == 0) begin
          report_mismatch("beat with nothing due", '0, got);
        end else begin
          want = parts_due.pop_front();
          if (got !== want) report_mismatch("mismatch", want, got);
        end
      end
    end
  end

  // driver
  always @(negedge clk) begin
    enum_req_t cur;
    if (!rst && !(s_axis_tvalid && !in_fire)) begin
      if (s_axis_tvalid) begin
        if ($urandom_range(0, 15) == 0) send_burst = !send_burst;
        gap_left = send_burst ? 0 : $urandom_range(0, 9);
      end
      if (gap_left > 0 || pending_items.size() == 0) begin
        if (gap_left > 0) gap_left--;
        s_axis_tvalid <= 1'b0;
      end else begin
        cur = pending_items.pop_front();
        s_axis_tuser <= cur.op;
        s_axis_tdata <= {{(ipe_pkg::BEAT_W-ipe_pkg::PART_W){1'b0}}, cur.total};
        s_axis_tvalid <= 1'b1;
      end
    end
  end

  // receiver stalls
  always @(negedge clk) begin
    if (!rst) begin
      if (out_fire) begin
        if ($urandom_range(0, 15) == 0) recv_burst = !recv_burst;
        stall_left = recv_burst ? 0 : $urandom_range(0, 9);
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin
    int target;
    int tot;
    int steps;
    for (int i = 0; i < MAX_TOTAL; i++) parts[i] = '0;

    // directed: bad starts, next with nothing running, full walk of 4, large total
    queue_item(ipe_pkg::OP_NEXT, 6'd0);
    queue_item(ipe_pkg::OP_START, 6'd0);
    queue_item(ipe_pkg::OP_START, 6'd33);
    queue_item(ipe_pkg::OP_START, 6'd63);
    queue_item(ipe_pkg::OP_NEXT, 6'd5);
    queue_item(ipe_pkg::OP_START, 6'd1);
    queue_item(ipe_pkg::OP_NEXT, 6'd1);
    queue_item(ipe_pkg::OP_START, 6'd4);
    repeat (4) queue_item(ipe_pkg::OP_NEXT, 6'd0);
    queue_item(ipe_pkg::OP_NEXT, 6'd0);
    queue_item(ipe_pkg::OP_NEXT, 6'd0);
    queue_item(ipe_pkg::OP_START, 6'd32);
    repeat (3) queue_item(ipe_pkg::OP_NEXT, 6'd63);
    queue_item(ipe_pkg::OP_START, 6'd2);
    queue_item(ipe_pkg::OP_NEXT, 6'd63);
    queue_item(ipe_pkg::OP_NEXT, 6'd42);
    queue_item(ipe_pkg::OP_NEXT, 6'd21);

    // random: mostly start followed by a run of nexts, some noise
    target = pending_items.size() + RANDOM_ITEMS;
    while (pending_items.size() < target) begin
      if ($urandom_range(0, 7) == 0) begin
        queue_item(1'($urandom_range(0, 1)), 6'($urandom_range(0, 63)));
      end else begin
        if ($urandom_range(0, 5) == 0) begin
          tot = $urandom_range(9, MAX_TOTAL);
          steps = $urandom_range(0, 4);
        end else begin
          tot = $urandom_range(1, 8);
          steps = $urandom_range(0, 24);
        end
        queue_item(ipe_pkg::OP_START, 6'(tot));
        repeat (steps) queue_item(ipe_pkg::OP_NEXT, 6'($urandom_range(0, 63)));
      end
    end

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    @(posedge clk);
    while (!(pending_items.size() == 0 && !s_axis_tvalid && parts_due.size() == 0)
           && cycles < CYCLE_LIMIT)
      @(posedge clk);

    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d items left, %0d beats due",
               cycles, pending_items.size(), parts_due.size());
      $display("** integer_partition_enumerator: FAILED **");
      $finish;
    end else begin
      repeat (DRAIN_CYCLES) @(posedge clk);
      if (parts_due.size() != 0) begin
        errors++;
        $display("%0d expected beats never arrived", parts_due.size());
      end
      $display("%0d requests, %0d partitions (up to %0d parts), %0d all-ones, %0d exhausted",
               items_taken, partitions_seen, widest, finals_seen, exhausted_seen);
      $display("%0d beats checked, %0d mismatches, %0d cycles", beats_checked, errors, cycles);
      if (errors == 0) begin
        $display("** integer_partition_enumerator: PASSED **");
      end else begin
        $display("** integer_partition_enumerator: FAILED **");
      end
      $finish;
    end
  end

endmodule
